@@ src/linear_probe_hash_table_defines.svh @@
// Assertion macros shared by the hash table RTL.
// Depends on nothing; included by the top level.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/lpht_pkg.sv @@
// Package for the linear probing hash table: field widths, codes, hash constants.
// No dependencies.
package lpht_pkg;

   localparam int KEY_BYTES = 16;
   localparam int KEY_W     = 128;
   localparam int LEN_W     = 5;
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 9;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;

   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 9'd179;
   localparam logic [LEN_W-1:0] KEY_LEN_MAX       = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED    = 3'd0,
      ST_OVERWRITTEN = 3'd1,
      ST_FOUND       = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_REMOVED     = 3'd4,
      ST_FULL        = 3'd5,
      ST_CLEARED     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

endpackage

@@ src/lpht_if.sv @@
// Handshake channels of the hash table: request, response and register write.
// Depends on lpht_pkg.
interface lpht_req_if import lpht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  opcode;
   logic [63:0]      key_lo;
   logic [63:0]      key_hi;
   logic [LEN_W-1:0] key_len;
   logic [VAL_W-1:0] value_in;

   modport source (output valid, opcode, key_lo, key_hi, key_len, value_in, input ready);
   modport sink   (input valid, opcode, key_lo, key_hi, key_len, value_in, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VAL_W-1:0]    value_out;

   modport source (output valid, status, value_out, input ready);
   modport sink   (input valid, status, value_out, output ready);
endinterface

interface lpht_csr_if import lpht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] max_entries;

   modport source (output valid, max_entries, input ready);
   modport sink   (input valid, max_entries, output ready);
endinterface

@@ src/linear_probe_hash_table.sv @@
// Key/value table, CAPACITY slots, FNV-1a home slot, linear probing with tombstones.
// One request at a time: the key is hashed one byte per cycle through a single
// FNV step unit, then the probe walk reads the slot memories with a read state
// and a check state per slot visited, then the done state updates the slots and
// loads the response once the response register is free. Clear sweeps the slot
// mark memory one slot a cycle; the same sweep runs after reset, during which no
// request is taken. Register writes are always accepted.
// Depends on lpht_pkg, lpht_if and linear_probe_hash_table_defines.svh.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic      clock,
   input  logic      reset,
   lpht_req_if.sink  req_chan,
   lpht_rsp_if.source rsp_chan,
   lpht_csr_if.sink  csr_chan
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W = LEN_W + KEY_W + VAL_W;
   localparam logic [31:0] CAP_32 = 32'(CAPACITY);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HASH  = 6'b000100,
      S_READ  = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   opcode_type          op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [31:0]         hash_ff, hash_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    free_ff, free_in;
   logic                have_free_ff, have_free_in;
   logic                hit_ff, hit_in;
   logic                clr_rsp_ff, clr_rsp_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [CFG_W-1:0]    max_ff, max_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [VAL_W-1:0]    vout_ff, vout_in;

   logic [1:0]          mark_mem [CAPACITY];
   logic [DATA_W-1:0]   data_mem [CAPACITY];
   logic [1:0]          mark_q;
   logic [DATA_W-1:0]   data_q;

   logic                mark_we, data_we;
   logic [IDX_W-1:0]    mark_wa, data_wa;
   mark_type            mark_wd;
   logic [DATA_W-1:0]   data_wd;

   logic                req_fire, done_fire;
   logic [LEN_W-1:0]    len_sat;
   logic [KEY_W-1:0]    key_raw, key_msk;
   logic [7:0]          hash_byte;
   logic [31:0]         lim32;
   logic                at_limit;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign done_fire = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.value_out = vout_ff;

   assign len_sat   = (req_chan.key_len > KEY_LEN_MAX) ? KEY_LEN_MAX : req_chan.key_len;
   assign key_raw   = {req_chan.key_hi, req_chan.key_lo};
   assign hash_byte = key_ff[{cnt_ff[3:0], 3'b000} +: 8];
   assign lim32     = ({23'b0, max_ff} > CAP_32) ? CAP_32 : {23'b0, max_ff};
   assign at_limit  = 32'(live_ff) >= lim32;

   always_comb begin
      for (int b = 0; b < KEY_BYTES; b++) begin
         key_msk[b*8 +: 8] = (5'(b) < len_sat) ? key_raw[b*8 +: 8] : 8'h00;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      hash_in      = hash_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      free_in      = free_ff;
      have_free_in = have_free_ff;
      hit_in       = hit_ff;
      clr_rsp_in   = clr_rsp_ff;
      live_in      = live_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      vout_in      = vout_ff;
      mark_we      = 1'b0;
      mark_wa      = idx_ff;
      mark_wd      = MARK_EMPTY;
      data_we      = 1'b0;
      data_wa      = idx_ff;
      data_wd      = {len_ff, key_ff, val_ff};

      if (csr_chan.valid) begin
         max_in = csr_chan.max_entries;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mark_we = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == '1) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in        = opcode_type'(req_chan.opcode);
               key_in       = key_msk;
               len_in       = len_sat;
               val_in       = req_chan.value_in;
               hash_in      = FNV_BASIS;
               cnt_in       = '0;
               n_in         = '0;
               have_free_in = 1'b0;
               hit_in       = 1'b0;
               if (opcode_type'(req_chan.opcode) == OP_CLEAR) begin
                  idx_in     = '0;
                  clr_rsp_in = 1'b1;
                  live_in    = '0;
                  state_in   = S_CLEAR;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (cnt_ff == len_ff) begin
               idx_in   = hash_ff[IDX_W-1:0];
               state_in = S_READ;
            end else begin
               hash_in = 32'((hash_ff ^ {24'b0, hash_byte}) * FNV_PRIME);
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (mark_q == MARK_LIVE && data_q[DATA_W-1:VAL_W] == {len_ff, key_ff}) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               if (mark_q != MARK_LIVE && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = idx_ff;
               end
               if (mark_q == MARK_EMPTY || n_ff == '1) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  n_in     = n_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            if (done_fire) begin
               rsp_valid_in = 1'b1;
               vout_in      = '0;
               status_in    = ST_NOT_FOUND;
               state_in     = S_IDLE;
               case (op_ff)
                  OP_CLEAR: begin
                     status_in  = ST_CLEARED;
                     clr_rsp_in = 1'b0;
                  end
                  OP_PUT: begin
                     if (hit_ff) begin
                        data_we   = 1'b1;
                        status_in = ST_OVERWRITTEN;
                     end else if (at_limit || !have_free_ff) begin
                        status_in = ST_FULL;
                     end else begin
                        mark_we   = 1'b1;
                        mark_wa   = free_ff;
                        mark_wd   = MARK_LIVE;
                        data_we   = 1'b1;
                        data_wa   = free_ff;
                        live_in   = live_ff + 1'b1;
                        status_in = ST_INSERTED;
                     end
                  end
                  OP_GET: begin
                     if (hit_ff) begin
                        status_in = ST_FOUND;
                        vout_in   = data_q[VAL_W-1:0];
                     end
                  end
                  default: begin
                     if (hit_ff) begin
                        mark_we   = 1'b1;
                        mark_wd   = MARK_TOMB;
                        status_in = ST_REMOVED;
                        if (live_ff != '0) begin
                           live_in = live_ff - 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      mark_q <= mark_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= data_wd;
      end
      data_q <= data_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         live_ff      <= '0;
         max_ff       <= MAX_ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         live_ff      <= live_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      len_ff       <= len_in;
      val_ff       <= val_in;
      hash_ff      <= hash_in;
      cnt_ff       <= cnt_in;
      n_ff         <= n_in;
      free_ff      <= free_in;
      have_free_ff <= have_free_in;
      hit_ff       <= hit_in;
      status_ff    <= status_in;
      vout_ff      <= vout_in;
   end

   `LPHT_ASSERT_NOW(a_check_after_read, clock, reset, state_ff == S_CHECK, $past(state_ff) == S_READ, "slot check without a preceding memory read")
   `LPHT_ASSERT_NOW(a_live_bound, clock, reset, 1'b1, 32'(live_ff) <= CAP_32, "live count above capacity")
   `LPHT_ASSERT_NEXT(a_insert_counts, clock, reset, done_fire && status_in == ST_INSERTED, live_ff == $past(live_ff) + CNT_W'(1), "insert did not bump live count")
   `LPHT_ASSERT_NOW(a_full_reason, clock, reset, done_fire && status_in == ST_FULL, at_limit || !have_free_ff, "full status without reason")

endmodule

@@ tb/lpht_tb_pkg.sv @@
`timescale 1ns / 1ps
// Predictor for the hash table testbench: FNV-1a home slot, linear probe walk,
// tombstones and entry limit. Depends on lpht_pkg.
package lpht_tb_pkg;
   import lpht_pkg::*;

   typedef struct packed {
      opcode_type       op;
      logic [63:0]      key_lo;
      logic [63:0]      key_hi;
      logic [LEN_W-1:0] key_len;
      logic [VAL_W-1:0] value;
   } table_req_t;

   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] value;
   } table_rsp_t;

   localparam int SLOTS = 256;

   mark_type         shadow_mark [SLOTS];
   logic [63:0]      shadow_lo   [SLOTS];
   logic [63:0]      shadow_hi   [SLOTS];
   logic [LEN_W-1:0] shadow_len  [SLOTS];
   logic [VAL_W-1:0] shadow_val  [SLOTS];
   int unsigned      shadow_live;
   logic [CFG_W-1:0] shadow_limit;

   function automatic void table_reset();
      foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
      shadow_live  = 0;
      shadow_limit = MAX_ENTRIES_RESET;
   endfunction

   function automatic logic [31:0] fnv1a(logic [127:0] k, int n);
      logic [31:0] h;
      h = FNV_BASIS;
      for (int i = 0; i < n; i++) begin
         h = h ^ {24'd0, k[8*i +: 8]};
         h = h * FNV_PRIME;
      end
      return h;
   endfunction

   function automatic table_rsp_t table_apply(table_req_t r);
      table_rsp_t   o;
      int           n, idx, free_idx, lim;
      bit           have_free, hit;
      logic [127:0] k;
      o.status = ST_NOT_FOUND;
      o.value  = '0;
      n = (r.key_len > KEY_LEN_MAX) ? KEY_BYTES : r.key_len;
      k = {r.key_hi, r.key_lo};
      for (int i = 0; i < 16; i++) if (i >= n) k[8*i +: 8] = 8'd0;
      if (r.op == OP_CLEAR) begin
         foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
         shadow_live = 0;
         o.status = ST_CLEARED;
         return o;
      end
      idx = fnv1a(k, n) & (SLOTS - 1);
      have_free = 0; hit = 0; free_idx = 0;
      for (int s = 0; s < SLOTS; s++) begin
         if (shadow_mark[idx] == MARK_LIVE) begin
            if (shadow_len[idx] == n && {shadow_hi[idx], shadow_lo[idx]} == k) begin
               hit = 1;
               break;
            end
         end else begin
            if (!have_free) begin
               have_free = 1;
               free_idx = idx;
            end
            if (shadow_mark[idx] == MARK_EMPTY) break;
         end
         idx = (idx + 1) & (SLOTS - 1);
      end
      case (r.op)
         OP_PUT: begin
            lim = (shadow_limit > SLOTS) ? SLOTS : shadow_limit;
            if (hit) begin
               shadow_val[idx] = r.value;
               o.status = ST_OVERWRITTEN;
            end else if (shadow_live >= lim || !have_free) begin
               o.status = ST_FULL;
            end else begin
               shadow_mark[free_idx] = MARK_LIVE;
               {shadow_hi[free_idx], shadow_lo[free_idx]} = k;
               shadow_len[free_idx] = n;
               shadow_val[free_idx] = r.value;
               shadow_live++;
               o.status = ST_INSERTED;
            end
         end
         OP_GET: if (hit) begin
            o.status = ST_FOUND;
            o.value  = shadow_val[idx];
         end
         default: if (hit) begin
            shadow_mark[idx] = MARK_TOMB;
            if (shadow_live > 0) shadow_live--;
            o.status = ST_REMOVED;
         end
      endcase
      return o;
   endfunction
endpackage

@@ tb/linear_probe_hash_table_tb.sv @@
`timescale 1ns / 1ps
// Testbench for linear_probe_hash_table: directed and random put/get/remove/clear
// traffic checked against a predictor. Depends on lpht_pkg, lpht_if, lpht_tb_pkg.
module linear_probe_hash_table_tb;
   import lpht_pkg::*;
   import lpht_tb_pkg::*;

   logic clock = 0;
   logic reset = 1;
   always #10 clock = ~clock;

   lpht_req_if req_chan ();
   lpht_rsp_if rsp_chan ();
   lpht_csr_if csr_chan ();

   linear_probe_hash_table uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   table_req_t pending_reqs[$];
   table_rsp_t expected_rsps[$];
   int  errors = 0;
   int  req_gap = 0, rsp_gap = 0, rsp_hold = 0;
   bit  quiet = 0, sender_pause = 0;
   int  idle_cycles = 0;
   int  sent = 0;
   logic [63:0] key_pool[8];

   initial begin
      req_chan.valid = 0;
      req_chan.opcode = OP_PUT;
      req_chan.key_lo = 0;
      req_chan.key_hi = 0;
      req_chan.key_len = 0;
      req_chan.value_in = 0;
      rsp_chan.ready = 0;
      csr_chan.valid = 0;
      csr_chan.max_entries = 0;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_rsps.push_back(table_apply(table_req_t'({req_chan.opcode,
               req_chan.key_lo, req_chan.key_hi, req_chan.key_len, req_chan.value_in})));
            sent++;
         end
         if (req_gap > 0 || sender_pause || pending_reqs.size() == 0) begin
            req_chan.valid <= 0;
            if (req_gap > 0) req_gap <= req_gap - 1;
         end else begin
            table_req_t r;
            r = pending_reqs.pop_front();
            req_chan.valid    <= 1;
            req_chan.opcode   <= r.op;
            req_chan.key_lo   <= r.key_lo;
            req_chan.key_hi   <= r.key_hi;
            req_chan.key_len  <= r.key_len;
            req_chan.value_in <= r.value;
            if (!quiet && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 16);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected transfer: status %0d", rsp_chan.status);
            errors++;
         end else begin
            table_rsp_t e;
            e = expected_rsps.pop_front();
            if (rsp_chan.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_chan.status);
               errors++;
            end
            if (rsp_chan.value_out !== e.value) begin
               $error("value_out: expected %h, got %h", e.value, rsp_chan.value_out);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_chan.ready <= 0;
      end else if (rsp_hold > 0) begin
         rsp_chan.ready <= 0;
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_gap > 0) begin
         rsp_chan.ready <= 0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_chan.ready <= 1;
         if (!quiet && $urandom_range(0, 11) == 0) rsp_gap <= $urandom_range(1, 16);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic table_req_t rand_req(int pool_bias);
      table_req_t r;
      int p;
      p = $urandom_range(0, 99);
      r.op = (p < 40) ? OP_PUT : (p < 70) ? OP_GET : (p < 98) ? OP_REMOVE : OP_CLEAR;
      r.key_hi = {$urandom, $urandom};
      r.key_len = $urandom_range(0, 31);
      if ($urandom_range(0, 99) < pool_bias) begin
         r.key_lo = key_pool[$urandom_range(0, 7)];
         r.key_len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 8;
      end else begin
         r.key_lo = {$urandom, $urandom};
      end
      r.value = $urandom;
      return r;
   endfunction

   task automatic csr_write(logic [CFG_W-1:0] v);
      while (expected_rsps.size() != 0 || pending_reqs.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (300) @(posedge clock);
      csr_chan.valid <= 1;
      csr_chan.max_entries <= v;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      table_limit_set(v);
      csr_chan.valid <= 0;
   endtask

   function automatic void table_limit_set(logic [CFG_W-1:0] v);
      shadow_limit = v;
   endfunction

   task automatic add(opcode_type op, logic [63:0] lo, logic [63:0] hi,
                      logic [LEN_W-1:0] n, logic [VAL_W-1:0] v);
      pending_reqs.push_back(table_req_t'({op, lo, hi, n, v}));
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      table_reset();
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed
      add(OP_GET, 0, 0, 0, 0);
      add(OP_PUT, 0, 0, 0, 32'hFFFF_FFFF);
      add(OP_GET, '1, '1, 0, 0);
      add(OP_PUT, '1, '1, 16, 32'h1234_5678);
      add(OP_PUT, '1, '1, 31, 32'h0);
      add(OP_GET, '1, '1, 16, 0);
      add(OP_PUT, '1, 64'h0, 8, 1);
      add(OP_GET, '1, 64'h55, 8, 0);
      add(OP_PUT, 64'hAA, 0, 1, 2);
      add(OP_GET, 64'hFFAA, 0, 1, 0);
      add(OP_REMOVE, '1, 0, 8, 0);
      add(OP_GET, '1, 0, 8, 0);
      add(OP_REMOVE, '1, 0, 8, 0);
      add(OP_PUT, '1, 0, 8, 3);
      add(OP_PUT, 64'h0123_4567_89AB_CDEF, 64'hFEDC, 12, 4);
      add(OP_GET, 64'h0123_4567_89AB_CDEF, 64'h1111_FEDC, 12, 0);
      add(OP_CLEAR, 0, 0, 0, 0);
      add(OP_GET, '1, 0, 8, 0);
      drain();
      // small limit, then zero, then the largest
      csr_write(9'd1);
      add(OP_PUT, 1, 0, 8, 5);
      add(OP_PUT, 2, 0, 8, 6);
      add(OP_PUT, 1, 0, 8, 7);
      add(OP_GET, 1, 0, 8, 0);
      drain();
      csr_write(9'd0);
      add(OP_PUT, 3, 0, 8, 8);
      add(OP_PUT, 1, 0, 8, 9);
      add(OP_CLEAR, 0, 0, 0, 0);
      drain();
      csr_write(9'd511);
      // fill the table completely to hit the walk-the-whole-table path
      for (int i = 0; i < 258; i++) add(OP_PUT, i, 0, 2, i);
      add(OP_GET, 64'hFFFF, 0, 2, 0);
      add(OP_REMOVE, 64'h0007, 0, 2, 0);
      add(OP_PUT, 64'h5555, 0, 2, 1);
      add(OP_CLEAR, 0, 0, 0, 0);
      // long receiver hold while the sender keeps offering
      for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req(80));
      rsp_hold = 400;
      drain();
      csr_write(9'd20);
      for (int i = 0; i < 200; i++) pending_reqs.push_back(rand_req(85));
      while (pending_reqs.size() > 100) @(posedge clock);
      sender_pause = 1;
      while (expected_rsps.size() != 0 || req_chan.valid) @(posedge clock);
      sender_pause = 0;
      drain();
      csr_write(9'd256);
      for (int i = 0; i < 80; i++) pending_reqs.push_back(rand_req(70));
      while (pending_reqs.size() > 50) @(posedge clock);
      quiet = 1;
      drain();
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+src
src/lpht_pkg.sv
src/lpht_if.sv
src/linear_probe_hash_table.sv
tb/lpht_tb_pkg.sv
tb/linear_probe_hash_table_tb.sv
